// ----- src/per_port_link_rate_meter_unit_defines.svh -----
`ifndef PER_PORT_LINK_RATE_METER_UNIT_DEFINES_SVH
`define PER_PORT_LINK_RATE_METER_UNIT_DEFINES_SVH

// same-cycle implication
`define PPLRM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPLRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/pplrm_pkg.sv -----
package pplrm_pkg;

   localparam int FUNC_W    = 2;
   localparam int PORT_W    = 4;
   localparam int CNT_W     = 16;
   localparam int MS_W      = 16;
   localparam int RATE_W    = 26;
   localparam int TIME_W    = 32;
   localparam int STEP_W    = $clog2(RATE_W);
   localparam int CSR_IDX_W = 1;

   localparam logic [9:0]      RATE_SCALE   = 10'd1000;
   localparam logic [MS_W-1:0] PERIOD_RESET = 16'd1000;
   localparam logic [MS_W-1:0] HOLD_RESET   = 16'd250;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_TX    = 2'd1,
      FUNC_RX    = 2'd2,
      FUNC_QUERY = 2'd3
   } func_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVITY_HOLD = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0]  tx_count;
      logic [CNT_W-1:0]  rx_count;
      logic [RATE_W-1:0] tx_rate;
      logic [RATE_W-1:0] rx_rate;
      logic [TIME_W-1:0] last_tx;
      logic [TIME_W-1:0] last_rx;
      logic              tx_seen;
      logic              rx_seen;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
      logic [MS_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [RATE_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- src/pplrm_div.sv -----
`include "per_port_link_rate_meter_unit_defines.svh"

module pplrm_div (
   input  logic                   clock,
   input  logic                   reset,
   input  pplrm_pkg::div_req_type div_req,
   output pplrm_pkg::div_rsp_type div_rsp
);
   import pplrm_pkg::*;

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_MUL  = 3'b010,
      D_RUN  = 3'b100
   } dst_type;

   dst_type           state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MS_W-1:0]   den_ff, den_in;
   logic [RATE_W-1:0] quo_ff, quo_in;
   logic [MS_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [MS_W:0]     rem_sh;
   logic [MS_W:0]     diff;
   logic              ge;

   assign rem_sh = {rem_ff, quo_ff[RATE_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               count_in = div_req.count;
               den_in   = div_req.den;
               state_in = D_MUL;
            end
         end
         D_MUL: begin
            quo_in   = {{(RATE_W-CNT_W){1'b0}}, count_ff} * RATE_W'(RATE_SCALE);
            rem_in   = '0;
            step_in  = '0;
            state_in = D_RUN;
         end
         D_RUN: begin
            quo_in  = {quo_ff[RATE_W-2:0], ge};
            rem_in  = ge ? diff[MS_W-1:0] : rem_sh[MS_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(RATE_W - 1)) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      count_ff <= count_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `PPLRM_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff, "divider done held two cycles")
   `PPLRM_ASSERT_NOW(a_start_idle, clock, reset, div_req.start, state_ff == D_IDLE, "divider started while busy")
   `PPLRM_ASSERT_NOW(a_den_nonzero, clock, reset, div_req.start, div_req.den != '0, "divider started with a zero divisor")

endmodule

// ----- src/per_port_link_rate_meter_unit.sv -----
// Per-port link rate meter.
// Input channel (req_): one word per tick, transmit event, receive event or
// status query; req_port names the port. Ticks advance the millisecond clock
// and the measurement window; events bump the port's saturating counts.
// Result channel (rsp_): one word per query with the held rates and activity
// flags; other words give no result. Out-of-range ports read as all zero.
// Configuration (csr_): sample period at index 0, activity hold at index 1;
// always ready, write only while the block is idle.
// Sequence: a tick that does not end a window leaves the block idle; an event
// or query reads the port memory, then updates it or loads the result. A window
// end runs a sweep over the port memory through one shift-subtract divider:
// per port a read and setup, then two 26-step divisions, tx then rx.
// Reset: a clearing pass writes every port entry to zero with req_ready low;
// period and hold return to 1000 and 250.
// A result waits in the output register while rsp_ready is low; a later
// query then holds in its result stage, and req_ready stays low until the
// pending word is taken.
`include "per_port_link_rate_meter_unit_defines.svh"

module per_port_link_rate_meter_unit #(
   parameter int NUM_PORTS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pplrm_pkg::FUNC_W-1:0]         req_func,
   input  logic [pplrm_pkg::PORT_W-1:0]         req_port,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_port_valid,
   output logic [pplrm_pkg::RATE_W-1:0]         rsp_tx_rate,
   output logic [pplrm_pkg::RATE_W-1:0]         rsp_rx_rate,
   output logic                                 rsp_tx_live,
   output logic                                 rsp_rx_live,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pplrm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pplrm_pkg::MS_W-1:0]           csr_wdata
);
   import pplrm_pkg::*;

   localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_EXEC   = 7'b0000100,
      S_SW_RD  = 7'b0001000,
      S_SW_TX  = 7'b0010000,
      S_SW_TXW = 7'b0100000,
      S_SW_RXW = 7'b1000000
   } st_type;

   st_type            state_ff, state_in;
   func_type          func_ff, func_in;
   logic              ok_ff, ok_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [MS_W-1:0]   window_ff, window_in;
   logic [MS_W-1:0]   den_ff, den_in;
   logic [MS_W-1:0]   period_ff, period_in;
   logic [MS_W-1:0]   hold_ff, hold_in;
   logic [RATE_W-1:0] tx_rate_ff, tx_rate_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [RATE_W-1:0] rsp_tx_rate_ff, rsp_tx_rate_in;
   logic [RATE_W-1:0] rsp_rx_rate_ff, rsp_rx_rate_in;
   logic              rsp_tx_act_ff, rsp_tx_act_in;
   logic              rsp_rx_act_ff, rsp_rx_act_in;

   entry_type         mem [NUM_PORTS];
   entry_type         rd_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              req_ok;
   logic              last_idx;
   logic [MS_W-1:0]   win_inc;
   logic              win_end;
   logic [TIME_W-1:0] tx_age;
   logic [TIME_W-1:0] rx_age;
   logic              tx_act;
   logic              rx_act;

   assign req_ok   = {1'b0, req_port} < (PORT_W + 1)'(NUM_PORTS);
   assign last_idx = idx_ff == IDX_W'(NUM_PORTS - 1);
   assign win_inc  = window_ff + 1'b1;
   assign win_end  = (win_inc >= period_ff) && (win_inc != '0);
   assign tx_age   = now_ff - rd_ff.last_tx;
   assign rx_age   = now_ff - rd_ff.last_rx;
   assign tx_act   = rd_ff.tx_seen && (tx_age <= {{(TIME_W-MS_W){1'b0}}, hold_ff});
   assign rx_act   = rd_ff.rx_seen && (rx_age <= {{(TIME_W-MS_W){1'b0}}, hold_ff});

   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      ok_in          = ok_ff;
      idx_in         = idx_ff;
      now_in         = now_ff;
      window_in      = window_ff;
      den_in         = den_ff;
      period_in      = period_ff;
      hold_in        = hold_ff;
      tx_rate_in     = tx_rate_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_ok_in      = rsp_ok_ff;
      rsp_tx_rate_in = rsp_tx_rate_ff;
      rsp_rx_rate_in = rsp_rx_rate_ff;
      rsp_tx_act_in  = rsp_tx_act_ff;
      rsp_rx_act_in  = rsp_rx_act_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff;
      mem_wdata      = rd_ff;
      mem_re         = 1'b0;
      mem_raddr      = idx_ff;
      div_req.start  = 1'b0;
      div_req.count  = rd_ff.tx_count;
      div_req.den    = den_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_PERIOD: period_in = csr_wdata;
            CSR_ACTIVITY_HOLD: hold_in   = csr_wdata;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (last_idx) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in = func_type'(req_func);
               ok_in   = req_ok;
               idx_in  = req_port[IDX_W-1:0];
               if (req_func == FUNC_TICK) begin
                  now_in = now_ff + 1'b1;
                  if (win_end) begin
                     window_in = '0;
                     den_in    = win_inc;
                     idx_in    = '0;
                     state_in  = S_SW_RD;
                  end else begin
                     window_in = win_inc;
                  end
               end else begin
                  mem_re    = req_ok;
                  mem_raddr = req_port[IDX_W-1:0];
                  state_in  = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            unique case (func_ff)
               FUNC_TX: begin
                  mem_we = ok_ff;
                  if (rd_ff.tx_count != '1) begin
                     mem_wdata.tx_count = rd_ff.tx_count + 1'b1;
                  end
                  mem_wdata.last_tx = now_ff;
                  mem_wdata.tx_seen = 1'b1;
                  state_in          = S_IDLE;
               end
               FUNC_RX: begin
                  mem_we = ok_ff;
                  if (rd_ff.rx_count != '1) begin
                     mem_wdata.rx_count = rd_ff.rx_count + 1'b1;
                  end
                  mem_wdata.last_rx = now_ff;
                  mem_wdata.rx_seen = 1'b1;
                  state_in          = S_IDLE;
               end
               FUNC_QUERY: begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     rsp_valid_in   = 1'b1;
                     rsp_ok_in      = ok_ff;
                     rsp_tx_rate_in = ok_ff ? rd_ff.tx_rate : '0;
                     rsp_rx_rate_in = ok_ff ? rd_ff.rx_rate : '0;
                     rsp_tx_act_in  = ok_ff && tx_act;
                     rsp_rx_act_in  = ok_ff && rx_act;
                     state_in       = S_IDLE;
                  end
               end
               FUNC_TICK: state_in = S_IDLE;
            endcase
         end
         S_SW_RD: begin
            mem_re   = 1'b1;
            state_in = S_SW_TX;
         end
         S_SW_TX: begin
            div_req.start = 1'b1;
            state_in      = S_SW_TXW;
         end
         S_SW_TXW: begin
            if (div_rsp.done) begin
               tx_rate_in    = div_rsp.quotient;
               div_req.start = 1'b1;
               div_req.count = rd_ff.rx_count;
               state_in      = S_SW_RXW;
            end
         end
         S_SW_RXW: begin
            if (div_rsp.done) begin
               mem_we             = 1'b1;
               mem_wdata.tx_count = '0;
               mem_wdata.rx_count = '0;
               mem_wdata.tx_rate  = tx_rate_ff;
               mem_wdata.rx_rate  = div_rsp.quotient;
               if (last_idx) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SW_RD;
               end
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         now_ff       <= '0;
         window_ff    <= '0;
         period_ff    <= PERIOD_RESET;
         hold_ff      <= HOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         now_ff       <= now_in;
         window_ff    <= window_in;
         period_ff    <= period_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff        <= func_in;
      ok_ff          <= ok_in;
      den_ff         <= den_in;
      tx_rate_ff     <= tx_rate_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_tx_rate_ff <= rsp_tx_rate_in;
      rsp_rx_rate_ff <= rsp_rx_rate_in;
      rsp_tx_act_ff  <= rsp_tx_act_in;
      rsp_rx_act_ff  <= rsp_rx_act_in;
   end

   pplrm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_port_valid = rsp_ok_ff;
   assign rsp_tx_rate    = rsp_tx_rate_ff;
   assign rsp_rx_rate    = rsp_rx_rate_ff;
   assign rsp_tx_live    = rsp_tx_act_ff;
   assign rsp_rx_live    = rsp_rx_act_ff;

   `PPLRM_ASSERT_NEXT(a_item_blocks, clock, reset, req_valid && req_ready && (req_func != FUNC_TICK), !req_ready, "ready high in the cycle after an event or query word")
   `PPLRM_ASSERT_NOW(a_write_state, clock, reset, mem_we, (state_ff == S_EXEC) || (state_ff == S_CLEAR) || (state_ff == S_SW_RXW), "port memory written outside an update state")
   `PPLRM_ASSERT_NOW(a_sweep_window, clock, reset, (state_ff == S_SW_RD) || (state_ff == S_SW_TX) || (state_ff == S_SW_TXW) || (state_ff == S_SW_RXW), window_ff == '0, "window counter not cleared during sweep")

endmodule
